FILE: rtl/core/bff_pkg.sv
// Shared types, constants and saturating fixed-point helpers of the boundary face flux block.
`default_nettype none

package bff_pkg;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned DIV_STEPS    = WORD_BITS + FRAC_BITS;
  localparam int unsigned DIV_LAT      = DIV_STEPS + 2;
  localparam int unsigned KIND_BITS    = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t Q_ONE    = word_t'(64'd1 << FRAC_BITS);
  localparam word_t Q_43     = word_t'(((64'd4 << FRAC_BITS) + 64'd1) / 64'd3);
  localparam word_t Q_23     = word_t'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);

  // Face kind codes
  localparam logic [KIND_BITS-1:0] KIND_INTERIOR    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_FARFIELD    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_OUTFLOW     = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_SLIP_WALL   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_NOSLIP_WALL = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_VISCOUS_ENABLE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FREE_U         = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FREE_V         = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FREE_PRESSURE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FREE_ENTHALPY  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_REYNOLDS   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEAT_COEF      = 3'd6;

  typedef struct packed {
    logic  viscous_enable;
    word_t free_u;
    word_t free_v;
    word_t free_pressure;
    word_t free_enthalpy;
    word_t inv_reynolds;
    word_t heat_coef;
  } cfg_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    word_t nx;
    word_t ny;
    word_t ox;
    word_t oy;
    word_t ro;
    word_t u;
    word_t v;
    word_t p;
    word_t et;
    word_t t;
    word_t mu;
  } face_t;

  typedef struct packed {
    logic conv_w;
    logic visc_w;
    logic far;
    logic outf;
    logic wall;
    logic nsw;
  } flags_t;

  typedef struct packed {
    flags_t fl;
    word_t  nx;
    word_t  ny;
    word_t  ox;
    word_t  oy;
    word_t  ro;
    word_t  u;
    word_t  v;
    word_t  p;
    word_t  et;
    word_t  mu;
    word_t  du;
    word_t  dv;
    word_t  dt;
  } item_t;

  typedef struct packed {
    logic  conv_written;
    word_t conv_mass;
    word_t conv_xmom;
    word_t conv_ymom;
    word_t conv_energy;
    logic  visc_written;
    word_t visc_xmom;
    word_t visc_ymom;
    word_t visc_energy;
  } res_t;

  // Clamp a sign and a wide magnitude to the word range
  function automatic word_t sat_mag(input logic neg, input logic [2*WORD_BITS-1:0] m);
    logic [2*WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0]   lo;
    lim = {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    lo  = m[WORD_BITS-1:0];
    if (m > lim) return neg ? WORD_MIN : WORD_MAX;
    return neg ? word_t'(~lo + 1'b1) : word_t'(lo);
  endfunction

  // Product with magnitude truncated toward zero, saturated
  function automatic word_t fmul(input word_t a, input word_t b);
    logic [WORD_BITS-1:0]   ma;
    logic [WORD_BITS-1:0]   mb;
    logic [2*WORD_BITS-1:0] pr;
    ma = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    mb = b[WORD_BITS-1] ? (~b + 1'b1) : b;
    pr = ma * mb;
    return sat_mag(a[WORD_BITS-1] ^ b[WORD_BITS-1], pr >> FRAC_BITS);
  endfunction

  function automatic word_t fadd(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t fsub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bff_front.sv
// Front end: accepts a face item, classifies its kind and forms the boundary differences.
`default_nettype none

module bff_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bff_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bff_pkg::face_t face_i,
  input  logic           full_i,
  output logic           push_o,
  output bff_pkg::item_t item_o
);
  import bff_pkg::*;

  logic  fv_q;
  item_t item_q;
  item_t item_d;
  logic  take;

  assign in_stall_o = fv_q & full_i;
  assign push_o     = fv_q & ~full_i;
  assign take       = in_valid_i & ~in_stall_o;
  assign item_o     = item_q;

  // Classify the kind and form the differences to the boundary values
  always_comb begin
    item_d.fl.far    = (face_i.kind == KIND_FARFIELD);
    item_d.fl.outf   = (face_i.kind == KIND_OUTFLOW);
    item_d.fl.nsw    = (face_i.kind == KIND_NOSLIP_WALL);
    item_d.fl.wall   = (face_i.kind == KIND_SLIP_WALL) | item_d.fl.nsw;
    item_d.fl.conv_w = item_d.fl.far | item_d.fl.outf | item_d.fl.wall;
    item_d.fl.visc_w = cfg_i.viscous_enable &
                       (item_d.fl.far | item_d.fl.outf | item_d.fl.nsw);
    item_d.nx = face_i.nx;
    item_d.ny = face_i.ny;
    item_d.ox = face_i.ox;
    item_d.oy = face_i.oy;
    item_d.ro = face_i.ro;
    item_d.u  = face_i.u;
    item_d.v  = face_i.v;
    item_d.p  = face_i.p;
    item_d.et = face_i.et;
    item_d.mu = face_i.mu;
    item_d.du = fsub(item_d.fl.far ? cfg_i.free_u : '0, face_i.u);
    item_d.dv = fsub(item_d.fl.far ? cfg_i.free_v : '0, face_i.v);
    item_d.dt = fsub(Q_ONE, face_i.t);
  end

  // Hold the item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= take | (fv_q & ~push_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bff_queue.sv
// Two-entry queue between the front end and the flux pipeline.
`default_nettype none

module bff_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bff_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bff_pkg::item_t item_o
);
  import bff_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  item_t      mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == QDEPTH);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bff_delay.sv
// Enabled shift line that aligns side data with the divider pipeline.
`default_nettype none

module bff_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  assign q_o = sr_q[DEPTH-1];

  // Shift one place per advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bff_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturated Q-format result.
`default_nettype none

module bff_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  bff_pkg::word_t num_i,
  input  bff_pkg::word_t den_i,
  output bff_pkg::word_t quo_o
);
  import bff_pkg::*;

  logic [WORD_BITS-1:0] rem_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic [WORD_BITS-1:0] den_q [DIV_STEPS+1];
  logic                 neg_q [DIV_STEPS+1];
  logic                 nz_q  [DIV_STEPS+1];
  word_t                out_q;
  logic [WORD_BITS-1:0] mnum;
  logic [WORD_BITS-1:0] mden;

  assign quo_o = out_q;
  assign mnum  = num_i[WORD_BITS-1] ? (~num_i + 1'b1) : num_i;
  assign mden  = den_i[WORD_BITS-1] ? (~den_i + 1'b1) : den_i;

  // Load magnitudes, scaled dividend and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= {mnum, {FRAC_BITS{1'b0}}};
      den_q[0] <= mden;
      neg_q[0] <= num_i[WORD_BITS-1] ^ den_i[WORD_BITS-1];
      nz_q[0]  <= (num_i != '0);
    end
  end

  // One restoring step per stage
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [WORD_BITS:0]   sh;
    logic                 ge;
    logic [WORD_BITS:0]   diff;

    assign sh   = {rem_q[g], quo_q[g][DIV_STEPS-1]};
    assign ge   = (sh >= {1'b0, den_q[g]});
    assign diff = sh - {1'b0, den_q[g]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1] <= ge ? diff[WORD_BITS-1:0] : sh[WORD_BITS-1:0];
        quo_q[g+1] <= {quo_q[g][DIV_STEPS-2:0], ge};
        den_q[g+1] <= den_q[g];
        neg_q[g+1] <= neg_q[g];
        nz_q[g+1]  <= nz_q[g];
      end
    end
  end

  // Saturate; a zero numerator always gives zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= nz_q[DIV_STEPS]
             ? sat_mag(neg_q[DIV_STEPS],
                       {{(2*WORD_BITS-DIV_STEPS){1'b0}}, quo_q[DIV_STEPS]})
             : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bff_back.sv
// Back end: convective and viscous flux pipeline with six gradient dividers.
`default_nettype none

module bff_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bff_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  bff_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bff_pkg::res_t  res_o
);
  import bff_pkg::*;

  localparam int unsigned NSLOT = DIV_LAT + 11;

  typedef struct packed {
    flags_t fl;
    word_t a1, a2, b1, b2, rou, rov, roet, p, nxp, nyp, nxfp, nyfp;
    word_t oxx, oyy, dux, duy, dvx, dvy, dtx, dty, c, ro, nx, ny;
  } s1_t;

  typedef struct packed {
    flags_t fl;
    word_t qn, vn, r2, roep, fhp, rou, rov, ro, nxp, nyp, nxfp, nyfp;
    word_t dux, duy, dvx, dvy, dtx, dty, c, nx, ny;
  } s2_t;

  typedef struct packed {
    flags_t fl;
    word_t qn, mro, xm, ym, e, nxp, nyp, nxfp, nyfp, c, nx, ny;
  } s3_t;

  typedef struct packed {
    flags_t fl;
    word_t cm, cx, cy, ce, c, nx, ny;
  } side_t;

  typedef struct packed {
    side_t sd;
    word_t a43x, a23y, a43y, a23x, sxy, qx, qy;
  } v1_t;

  typedef struct packed {
    side_t sd;
    word_t axx, ayy, sxy, qx, qy;
  } v2_t;

  typedef struct packed {
    side_t sd;
    word_t txx, txy, tyy, qx, qy;
  } v3_t;

  typedef struct packed {
    side_t sd;
    word_t nxtxx, nytxy, nxtxy, nytyy, futxx, fvtxy, futxy, fvtyy, qx, qy;
  } v4_t;

  typedef struct packed {
    side_t sd;
    word_t vx, vy, e1, e2, qx, qy;
  } v5_t;

  typedef struct packed {
    side_t sd;
    word_t vx, vy, ex, ey;
  } v6_t;

  typedef struct packed {
    side_t sd;
    word_t vx, vy, mx, my;
  } v7_t;

  typedef struct packed {
    side_t sd;
    word_t vx, vy, ve;
  } v8_t;

  logic [NSLOT-1:0] vld_q;
  logic             adv;

  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  s3_t   s3_d, s3_q;
  side_t s4_d, s4_q;
  side_t sd_al;
  v1_t   v1_d, v1_q;
  v2_t   v2_d, v2_q;
  v3_t   v3_d, v3_q;
  v4_t   v4_d, v4_q;
  v5_t   v5_d, v5_q;
  v6_t   v6_d, v6_q;
  v7_t   v7_d, v7_q;
  v8_t   v8_d, v8_q;
  res_t  res_d, res_q;
  word_t gux, guy, gvx, gvy, gtx, gty;
  logic  vz;

  assign adv         = ~(vld_q[NSLOT-1] & out_stall_i);
  assign q_pop_o     = adv & q_valid_i;
  assign out_valid_o = vld_q[NSLOT-1];
  assign res_o       = res_q;

  // Advance valid bits with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSLOT-2:0], q_valid_i};
    end
  end

  // First products from the cell state
  always_comb begin
    s1_d.fl   = q_item_i.fl;
    s1_d.a1   = fmul(cfg_i.free_u, q_item_i.nx);
    s1_d.a2   = fmul(cfg_i.free_v, q_item_i.ny);
    s1_d.b1   = fmul(q_item_i.u, q_item_i.nx);
    s1_d.b2   = fmul(q_item_i.v, q_item_i.ny);
    s1_d.rou  = fmul(q_item_i.ro, q_item_i.u);
    s1_d.rov  = fmul(q_item_i.ro, q_item_i.v);
    s1_d.roet = fmul(q_item_i.ro, q_item_i.et);
    s1_d.p    = q_item_i.p;
    s1_d.nxp  = fmul(q_item_i.nx, q_item_i.p);
    s1_d.nyp  = fmul(q_item_i.ny, q_item_i.p);
    s1_d.nxfp = fmul(q_item_i.nx, cfg_i.free_pressure);
    s1_d.nyfp = fmul(q_item_i.ny, cfg_i.free_pressure);
    s1_d.oxx  = fmul(q_item_i.ox, q_item_i.ox);
    s1_d.oyy  = fmul(q_item_i.oy, q_item_i.oy);
    s1_d.dux  = fmul(q_item_i.du, q_item_i.ox);
    s1_d.duy  = fmul(q_item_i.du, q_item_i.oy);
    s1_d.dvx  = fmul(q_item_i.dv, q_item_i.ox);
    s1_d.dvy  = fmul(q_item_i.dv, q_item_i.oy);
    s1_d.dtx  = fmul(q_item_i.dt, q_item_i.ox);
    s1_d.dty  = fmul(q_item_i.dt, q_item_i.oy);
    s1_d.c    = q_item_i.fl.far ? cfg_i.inv_reynolds
                                : fmul(q_item_i.mu, cfg_i.inv_reynolds);
    s1_d.ro   = q_item_i.ro;
    s1_d.nx   = q_item_i.nx;
    s1_d.ny   = q_item_i.ny;
  end

  // Normal velocities, squared offset length and energy terms
  always_comb begin
    s2_d.fl   = s1_q.fl;
    s2_d.qn   = fadd(s1_q.a1, s1_q.a2);
    s2_d.vn   = fadd(s1_q.b1, s1_q.b2);
    s2_d.r2   = fadd(s1_q.oxx, s1_q.oyy);
    s2_d.roep = fadd(s1_q.roet, s1_q.p);
    s2_d.fhp  = fadd(cfg_i.free_enthalpy, cfg_i.free_pressure);
    s2_d.rou  = s1_q.rou;
    s2_d.rov  = s1_q.rov;
    s2_d.ro   = s1_q.ro;
    s2_d.nxp  = s1_q.nxp;
    s2_d.nyp  = s1_q.nyp;
    s2_d.nxfp = s1_q.nxfp;
    s2_d.nyfp = s1_q.nyfp;
    s2_d.dux  = s1_q.dux;
    s2_d.duy  = s1_q.duy;
    s2_d.dvx  = s1_q.dvx;
    s2_d.dvy  = s1_q.dvy;
    s2_d.dtx  = s1_q.dtx;
    s2_d.dty  = s1_q.dty;
    s2_d.c    = s1_q.c;
    s2_d.nx   = s1_q.nx;
    s2_d.ny   = s1_q.ny;
  end

  // Convective products, shared between farfield and outflow
  always_comb begin
    s3_d.fl   = s2_q.fl;
    s3_d.qn   = s2_q.qn;
    s3_d.mro  = fmul(s2_q.ro, s2_q.vn);
    s3_d.xm   = fmul(s2_q.fl.far ? cfg_i.free_u : s2_q.rou,
                     s2_q.fl.far ? s2_q.qn : s2_q.vn);
    s3_d.ym   = fmul(s2_q.fl.far ? cfg_i.free_v : s2_q.rov,
                     s2_q.fl.far ? s2_q.qn : s2_q.vn);
    s3_d.e    = fmul(s2_q.fl.far ? s2_q.fhp : s2_q.roep,
                     s2_q.fl.far ? s2_q.qn : s2_q.vn);
    s3_d.nxp  = s2_q.nxp;
    s3_d.nyp  = s2_q.nyp;
    s3_d.nxfp = s2_q.nxfp;
    s3_d.nyfp = s2_q.nyfp;
    s3_d.c    = s2_q.c;
    s3_d.nx   = s2_q.nx;
    s3_d.ny   = s2_q.ny;
  end

  // Finish the convective flux for each kind
  always_comb begin
    s4_d.fl = s3_q.fl;
    s4_d.cm = s3_q.fl.far ? s3_q.qn : (s3_q.fl.outf ? s3_q.mro : '0);
    if (s3_q.fl.wall) begin
      s4_d.cx = s3_q.nxp;
      s4_d.cy = s3_q.nyp;
    end else if (s3_q.fl.far) begin
      s4_d.cx = fadd(s3_q.xm, s3_q.nxfp);
      s4_d.cy = fadd(s3_q.ym, s3_q.nyfp);
    end else if (s3_q.fl.outf) begin
      s4_d.cx = fadd(s3_q.xm, s3_q.nxp);
      s4_d.cy = fadd(s3_q.ym, s3_q.nyp);
    end else begin
      s4_d.cx = '0;
      s4_d.cy = '0;
    end
    s4_d.ce = (s3_q.fl.far | s3_q.fl.outf) ? s3_q.e : '0;
    s4_d.c  = s3_q.c;
    s4_d.nx = s3_q.nx;
    s4_d.ny = s3_q.ny;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  // Gradients: product over squared offset length
  bff_div u_div_ux (.clk_i, .en_i(adv), .num_i(s2_q.dux), .den_i(s2_q.r2), .quo_o(gux));
  bff_div u_div_uy (.clk_i, .en_i(adv), .num_i(s2_q.duy), .den_i(s2_q.r2), .quo_o(guy));
  bff_div u_div_vx (.clk_i, .en_i(adv), .num_i(s2_q.dvx), .den_i(s2_q.r2), .quo_o(gvx));
  bff_div u_div_vy (.clk_i, .en_i(adv), .num_i(s2_q.dvy), .den_i(s2_q.r2), .quo_o(gvy));
  bff_div u_div_tx (.clk_i, .en_i(adv), .num_i(s2_q.dtx), .den_i(s2_q.r2), .quo_o(gtx));
  bff_div u_div_ty (.clk_i, .en_i(adv), .num_i(s2_q.dty), .den_i(s2_q.r2), .quo_o(gty));

  // Carry the side data alongside the dividers
  bff_delay #(
    .WIDTH($bits(side_t)),
    .DEPTH(DIV_LAT - 2)
  ) u_side_dly (
    .clk_i,
    .en_i(adv),
    .d_i  (s4_q),
    .q_o  (sd_al)
  );

  // Scale gradients and heat flux
  always_comb begin
    v1_d.sd   = sd_al;
    v1_d.a43x = fmul(Q_43, gux);
    v1_d.a23y = fmul(Q_23, gvy);
    v1_d.a43y = fmul(Q_43, gvy);
    v1_d.a23x = fmul(Q_23, gux);
    v1_d.sxy  = fadd(guy, gvx);
    v1_d.qx   = fmul(cfg_i.heat_coef, gtx);
    v1_d.qy   = fmul(cfg_i.heat_coef, gty);
  end

  always_comb begin
    v2_d.sd  = v1_q.sd;
    v2_d.axx = fsub(v1_q.a43x, v1_q.a23y);
    v2_d.ayy = fsub(v1_q.a43y, v1_q.a23x);
    v2_d.sxy = v1_q.sxy;
    v2_d.qx  = v1_q.qx;
    v2_d.qy  = v1_q.qy;
  end

  // Shear stresses
  always_comb begin
    v3_d.sd  = v2_q.sd;
    v3_d.txx = fmul(v2_q.sd.c, v2_q.axx);
    v3_d.txy = fmul(v2_q.sd.c, v2_q.sxy);
    v3_d.tyy = fmul(v2_q.sd.c, v2_q.ayy);
    v3_d.qx  = v2_q.qx;
    v3_d.qy  = v2_q.qy;
  end

  always_comb begin
    v4_d.sd    = v3_q.sd;
    v4_d.nxtxx = fmul(v3_q.sd.nx, v3_q.txx);
    v4_d.nytxy = fmul(v3_q.sd.ny, v3_q.txy);
    v4_d.nxtxy = fmul(v3_q.sd.nx, v3_q.txy);
    v4_d.nytyy = fmul(v3_q.sd.ny, v3_q.tyy);
    v4_d.futxx = fmul(cfg_i.free_u, v3_q.txx);
    v4_d.fvtxy = fmul(cfg_i.free_v, v3_q.txy);
    v4_d.futxy = fmul(cfg_i.free_u, v3_q.txy);
    v4_d.fvtyy = fmul(cfg_i.free_v, v3_q.tyy);
    v4_d.qx    = v3_q.qx;
    v4_d.qy    = v3_q.qy;
  end

  always_comb begin
    v5_d.sd = v4_q.sd;
    v5_d.vx = fadd(v4_q.nxtxx, v4_q.nytxy);
    v5_d.vy = fadd(v4_q.nxtxy, v4_q.nytyy);
    v5_d.e1 = fadd(v4_q.futxx, v4_q.fvtxy);
    v5_d.e2 = fadd(v4_q.futxy, v4_q.fvtyy);
    v5_d.qx = v4_q.qx;
    v5_d.qy = v4_q.qy;
  end

  always_comb begin
    v6_d.sd = v5_q.sd;
    v6_d.vx = v5_q.vx;
    v6_d.vy = v5_q.vy;
    v6_d.ex = fadd(v5_q.e1, v5_q.qx);
    v6_d.ey = fadd(v5_q.e2, v5_q.qy);
  end

  always_comb begin
    v7_d.sd = v6_q.sd;
    v7_d.vx = v6_q.vx;
    v7_d.vy = v6_q.vy;
    v7_d.mx = fmul(v6_q.sd.nx, v6_q.ex);
    v7_d.my = fmul(v6_q.sd.ny, v6_q.ey);
  end

  always_comb begin
    v8_d.sd = v7_q.sd;
    v8_d.vx = v7_q.vx;
    v8_d.vy = v7_q.vy;
    v8_d.ve = fadd(v7_q.mx, v7_q.my);
  end

  // Select the result fields by kind
  always_comb begin
    vz = v8_q.sd.fl.visc_w & ~v8_q.sd.fl.outf;
    res_d.conv_written = v8_q.sd.fl.conv_w;
    res_d.conv_mass    = v8_q.sd.cm;
    res_d.conv_xmom    = v8_q.sd.cx;
    res_d.conv_ymom    = v8_q.sd.cy;
    res_d.conv_energy  = v8_q.sd.ce;
    res_d.visc_written = v8_q.sd.fl.visc_w;
    res_d.visc_xmom    = vz ? v8_q.vx : '0;
    res_d.visc_ymom    = vz ? v8_q.vy : '0;
    res_d.visc_energy  = (vz & v8_q.sd.fl.far) ? v8_q.ve : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_q  <= v1_d;
      v2_q  <= v2_d;
      v3_q  <= v3_d;
      v4_q  <= v4_d;
      v5_q  <= v5_d;
      v6_q  <= v6_d;
      v7_q  <= v7_d;
      v8_q  <= v8_d;
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/boundary_face_flux.sv
// Top level of the boundary face flux block: configuration registers, front end, queue, pipeline.
`default_nettype none

// Computes the convective and viscous flux through one boundary face of a 2D quad cell in
// saturating Q16.16. One face item is accepted per clock cycle unless the input stalls, and
// one result item comes out per item, in order. An item passes through one front register,
// the two-entry queue, and a 61-stage flux pipeline whose length is set by the six 48-step
// pipelined dividers that form the gradients. Stalling the output freezes the pipeline; the
// queue and front register then absorb up to three more items before the input stalls.
// Configuration is to be written while no item is in flight; the block does not enforce it.
module boundary_face_flux (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bff_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [bff_pkg::WORD_BITS-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bff_pkg::KIND_BITS-1:0]    face_kind_i,
  input  bff_pkg::word_t                   normal_x_i,
  input  bff_pkg::word_t                   normal_y_i,
  input  bff_pkg::word_t                   offset_x_i,
  input  bff_pkg::word_t                   offset_y_i,
  input  bff_pkg::word_t                   density_i,
  input  bff_pkg::word_t                   vel_u_i,
  input  bff_pkg::word_t                   vel_v_i,
  input  bff_pkg::word_t                   pressure_i,
  input  bff_pkg::word_t                   energy_i,
  input  bff_pkg::word_t                   temperature_i,
  input  bff_pkg::word_t                   viscosity_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             conv_written_o,
  output bff_pkg::word_t                   conv_mass_o,
  output bff_pkg::word_t                   conv_xmom_o,
  output bff_pkg::word_t                   conv_ymom_o,
  output bff_pkg::word_t                   conv_energy_o,
  output logic                             visc_written_o,
  output bff_pkg::word_t                   visc_xmom_o,
  output bff_pkg::word_t                   visc_ymom_o,
  output bff_pkg::word_t                   visc_energy_o
);
  import bff_pkg::*;

  cfg_t  cfg_q;
  face_t face;
  item_t f_item;
  item_t q_item;
  logic  push;
  logic  full;
  logic  pop;
  logic  q_valid;
  res_t  res;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.viscous_enable <= 1'b0;
      cfg_q.free_u         <= Q_ONE;
      cfg_q.free_v         <= '0;
      cfg_q.free_pressure  <= '0;
      cfg_q.free_enthalpy  <= '0;
      cfg_q.inv_reynolds   <= '0;
      cfg_q.heat_coef      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VISCOUS_ENABLE: cfg_q.viscous_enable <= cfg_data_i[0];
        REG_FREE_U:         cfg_q.free_u         <= word_t'(cfg_data_i);
        REG_FREE_V:         cfg_q.free_v         <= word_t'(cfg_data_i);
        REG_FREE_PRESSURE:  cfg_q.free_pressure  <= word_t'(cfg_data_i);
        REG_FREE_ENTHALPY:  cfg_q.free_enthalpy  <= word_t'(cfg_data_i);
        REG_INV_REYNOLDS:   cfg_q.inv_reynolds   <= word_t'(cfg_data_i);
        REG_HEAT_COEF:      cfg_q.heat_coef      <= word_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Gather the input item
  always_comb begin
    face.kind = face_kind_i;
    face.nx   = normal_x_i;
    face.ny   = normal_y_i;
    face.ox   = offset_x_i;
    face.oy   = offset_y_i;
    face.ro   = density_i;
    face.u    = vel_u_i;
    face.v    = vel_v_i;
    face.p    = pressure_i;
    face.et   = energy_i;
    face.t    = temperature_i;
    face.mu   = viscosity_i;
  end

  bff_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .face_i    (face),
    .full_i    (full),
    .push_o    (push),
    .item_o    (f_item)
  );

  bff_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  bff_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (pop),
    .out_valid_o,
    .out_stall_i,
    .res_o      (res)
  );

  assign conv_written_o = res.conv_written;
  assign conv_mass_o    = res.conv_mass;
  assign conv_xmom_o    = res.conv_xmom;
  assign conv_ymom_o    = res.conv_ymom;
  assign conv_energy_o  = res.conv_energy;
  assign visc_written_o = res.visc_written;
  assign visc_xmom_o    = res.visc_xmom;
  assign visc_ymom_o    = res.visc_ymom;
  assign visc_energy_o  = res.visc_energy;

endmodule

`default_nettype wire

FILE: test/tb_boundary_face_flux.sv
// Self-checking testbench for the boundary face flux block.
`default_nettype none

module tb_boundary_face_flux;
  import bff_pkg::*;

  localparam int WATCH_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int WB = WORD_BITS;
  localparam int FB = FRAC_BITS;

  typedef logic signed [WB-1:0] q_t;

  typedef struct {
    logic [KIND_BITS-1:0] kind;
    q_t nx, ny, ox, oy, ro, u, v, p, et, t, mu;
  } face_item_t;

  typedef struct {
    logic cw;
    q_t cm, cx, cy, ce;
    logic vw;
    q_t vx, vy, ve;
  } flux_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [WB-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KIND_BITS-1:0] face_kind_i = '0;
  q_t normal_x_i = '0, normal_y_i = '0, offset_x_i = '0, offset_y_i = '0;
  q_t density_i = '0, vel_u_i = '0, vel_v_i = '0, pressure_i = '0;
  q_t energy_i = '0, temperature_i = '0, viscosity_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic conv_written_o, visc_written_o;
  q_t conv_mass_o, conv_xmom_o, conv_ymom_o, conv_energy_o;
  q_t visc_xmom_o, visc_ymom_o, visc_energy_o;

  boundary_face_flux u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers
  logic m_visc = 1'b0;
  q_t m_fu = q_t'(64'd1 << FB), m_fv = '0, m_fp = '0, m_fh = '0, m_ire = '0, m_hc = '0;

  flux_item_t flux_q[$];
  int errors = 0;
  int faces_sent = 0;
  int fluxes_seen = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int kind_hits[8];

  // Saturating fixed-point arithmetic at the block word width
  localparam logic signed [127:0] W_MAX = (128'sd1 <<< (WB - 1)) - 1;
  localparam logic signed [127:0] W_MIN = -(128'sd1 <<< (WB - 1));

  function automatic q_t sat(input logic signed [127:0] x);
    if (x > W_MAX) return q_t'(W_MAX);
    if (x < W_MIN) return q_t'(W_MIN);
    return q_t'(x);
  endfunction

  function automatic q_t q_add(input q_t a, input q_t b);
    logic signed [127:0] sa, sb;
    sa = a;
    sb = b;
    return sat(sa + sb);
  endfunction

  function automatic q_t q_sub(input q_t a, input q_t b);
    logic signed [127:0] sa, sb;
    sa = a;
    sb = b;
    return sat(sa - sb);
  endfunction

  function automatic q_t q_mul(input q_t a, input q_t b);
    logic signed [127:0] sa, sb, m;
    sa = a;
    sb = b;
    m = (sa < 0 ? -sa : sa) * (sb < 0 ? -sb : sb);
    m = m >>> FB;
    return sat(((a < 0) != (b < 0)) ? -m : m);
  endfunction

  function automatic q_t q_div(input q_t a, input q_t b);
    logic signed [127:0] sa, sb, qt;
    sa = a;
    sb = b;
    if (b == 0) return a > 0 ? q_t'(W_MAX) : (a < 0 ? q_t'(W_MIN) : q_t'(0));
    qt = ((sa < 0 ? -sa : sa) <<< FB) / (sb < 0 ? -sb : sb);
    return sat(((a < 0) != (b < 0)) ? -qt : qt);
  endfunction

  function automatic q_t slope(input q_t d, input q_t o, input q_t r2);
    return q_div(q_mul(d, o), r2);
  endfunction

  // Predict the flux item of one face from the shadow registers
  function automatic flux_item_t face_flux(input face_item_t f);
    flux_item_t r;
    q_t one, c43, c23, qn, vn, r2, dt, qx, qy, du, dv, c, gux, guy, gvx, gvy;
    q_t txx, txy, tyy;
    one = q_t'(64'd1 << FB);
    c43 = q_t'(((64'd4 << FB) + 1) / 3);
    c23 = q_t'(((64'd2 << FB) + 1) / 3);
    r = '{default: '0};
    case (f.kind)
      KIND_FARFIELD: begin
        qn = q_add(q_mul(m_fu, f.nx), q_mul(m_fv, f.ny));
        r.cw = 1'b1;
        r.cm = qn;
        r.cx = q_add(q_mul(m_fu, qn), q_mul(f.nx, m_fp));
        r.cy = q_add(q_mul(m_fv, qn), q_mul(f.ny, m_fp));
        r.ce = q_mul(q_add(m_fh, m_fp), qn);
      end
      KIND_OUTFLOW: begin
        vn = q_add(q_mul(f.u, f.nx), q_mul(f.v, f.ny));
        r.cw = 1'b1;
        r.cm = q_mul(f.ro, vn);
        r.cx = q_add(q_mul(q_mul(f.ro, f.u), vn), q_mul(f.nx, f.p));
        r.cy = q_add(q_mul(q_mul(f.ro, f.v), vn), q_mul(f.ny, f.p));
        r.ce = q_mul(q_add(q_mul(f.ro, f.et), f.p), vn);
      end
      KIND_SLIP_WALL, KIND_NOSLIP_WALL: begin
        r.cw = 1'b1;
        r.cx = q_mul(f.nx, f.p);
        r.cy = q_mul(f.ny, f.p);
      end
      default: ;
    endcase
    if (m_visc && (f.kind == KIND_FARFIELD || f.kind == KIND_OUTFLOW ||
                   f.kind == KIND_NOSLIP_WALL)) begin
      r.vw = 1'b1;
      if (f.kind != KIND_OUTFLOW) begin
        r2 = q_add(q_mul(f.ox, f.ox), q_mul(f.oy, f.oy));
        if (f.kind == KIND_FARFIELD) begin
          du = q_sub(m_fu, f.u);
          dv = q_sub(m_fv, f.v);
          c = m_ire;
        end else begin
          du = q_sub('0, f.u);
          dv = q_sub('0, f.v);
          c = q_mul(f.mu, m_ire);
        end
        gux = slope(du, f.ox, r2);
        guy = slope(du, f.oy, r2);
        gvx = slope(dv, f.ox, r2);
        gvy = slope(dv, f.oy, r2);
        txx = q_mul(c, q_sub(q_mul(c43, gux), q_mul(c23, gvy)));
        txy = q_mul(c, q_add(guy, gvx));
        tyy = q_mul(c, q_sub(q_mul(c43, gvy), q_mul(c23, gux)));
        r.vx = q_add(q_mul(f.nx, txx), q_mul(f.ny, txy));
        r.vy = q_add(q_mul(f.nx, txy), q_mul(f.ny, tyy));
        if (f.kind == KIND_FARFIELD) begin
          dt = q_sub(one, f.t);
          qx = q_mul(m_hc, slope(dt, f.ox, r2));
          qy = q_mul(m_hc, slope(dt, f.oy, r2));
          r.ve = q_add(q_mul(f.nx, q_add(q_add(q_mul(m_fu, txx), q_mul(m_fv, txy)), qx)),
                       q_mul(f.ny, q_add(q_add(q_mul(m_fu, txy), q_mul(m_fv, tyy)), qy)));
        end
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [WB-1:0] got,
                        input logic [WB-1:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, fluxes_seen);
  endtask

  // Check each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    flux_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (flux_q.size() == 0) begin
        report("unexpected item", '0, '0);
      end else begin
        e = flux_q.pop_front();
        if (conv_written_o !== e.cw)
          report("conv_written", WB'(conv_written_o), WB'(e.cw));
        if (conv_mass_o !== e.cm) report("conv_mass", conv_mass_o, e.cm);
        if (conv_xmom_o !== e.cx) report("conv_xmom", conv_xmom_o, e.cx);
        if (conv_ymom_o !== e.cy) report("conv_ymom", conv_ymom_o, e.cy);
        if (conv_energy_o !== e.ce) report("conv_energy", conv_energy_o, e.ce);
        if (visc_written_o !== e.vw)
          report("visc_written", WB'(visc_written_o), WB'(e.vw));
        if (visc_xmom_o !== e.vx) report("visc_xmom", visc_xmom_o, e.vx);
        if (visc_ymom_o !== e.vy) report("visc_ymom", visc_ymom_o, e.vy);
        if (visc_energy_o !== e.ve) report("visc_energy", visc_energy_o, e.ve);
      end
      fluxes_seen++;
    end
  end

  // Stall the output on a pattern that changes per phase
  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input q_t val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_VISCOUS_ENABLE: m_visc = val[0];
      REG_FREE_U: m_fu = val;
      REG_FREE_V: m_fv = val;
      REG_FREE_PRESSURE: m_fp = val;
      REG_FREE_ENTHALPY: m_fh = val;
      REG_INV_REYNOLDS: m_ire = val;
      REG_HEAT_COEF: m_hc = val;
      default: ;
    endcase
  endtask

  // Hold valid until the item is taken; keep valid high for back-to-back items,
  // otherwise drop it for one idle cycle
  task automatic send_face(input face_item_t f, input bit keep);
    face_kind_i <= f.kind;
    normal_x_i <= f.nx;
    normal_y_i <= f.ny;
    offset_x_i <= f.ox;
    offset_y_i <= f.oy;
    density_i <= f.ro;
    vel_u_i <= f.u;
    vel_v_i <= f.v;
    pressure_i <= f.p;
    energy_i <= f.et;
    temperature_i <= f.t;
    viscosity_i <= f.mu;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    flux_q.push_back(face_flux(f));
    kind_hits[f.kind]++;
    faces_sent++;
    @(negedge clk_i);
    if (!keep) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (flux_q.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic q_t rand_word();
    case ($urandom_range(0, 7))
      0: return q_t'(W_MAX);
      1: return q_t'(W_MIN);
      2: return '0;
      3, 4: return q_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      5: return q_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
      default: return q_t'($urandom);
    endcase
  endfunction

  function automatic face_item_t rand_face();
    face_item_t f;
    f.kind = ($urandom_range(0, 9) == 0) ? KIND_BITS'($urandom_range(0, 7))
                                         : KIND_BITS'($urandom_range(1, 4));
    f.nx = rand_word(); f.ny = rand_word(); f.ox = rand_word(); f.oy = rand_word();
    f.ro = rand_word(); f.u = rand_word(); f.v = rand_word(); f.p = rand_word();
    f.et = rand_word(); f.t = rand_word(); f.mu = rand_word();
    return f;
  endfunction

  function automatic face_item_t fill_face(input logic [KIND_BITS-1:0] k, input q_t val);
    face_item_t f;
    f = '{kind: k, nx: val, ny: val, ox: val, oy: val, ro: val, u: val, v: val, p: val,
          et: val, t: val, mu: val};
    return f;
  endfunction

  // Directed faces: every kind, field extremes and zero offset
  task automatic test_directed();
    face_item_t f;
    for (int k = 0; k < 8; k++) send_face(fill_face(KIND_BITS'(k), q_t'(64'd1 << FB)), 0);
    send_face(fill_face(KIND_FARFIELD, q_t'(W_MAX)), 1);
    send_face(fill_face(KIND_OUTFLOW, q_t'(W_MIN)), 1);
    send_face(fill_face(KIND_NOSLIP_WALL, q_t'(W_MAX)), 1);
    send_face(fill_face(KIND_SLIP_WALL, q_t'(W_MIN)), 1);
    f = fill_face(KIND_FARFIELD, q_t'(32'sh18000));
    f.ox = '0;
    f.oy = '0;
    send_face(f, 1);
    f.kind = KIND_NOSLIP_WALL;
    send_face(f, 1);
    f.u = '0;
    f.v = '0;
    f.t = q_t'(64'd1 << FB);
    f.kind = KIND_FARFIELD;
    send_face(f, 0);
    drain();
  endtask

  // Random faces in bursts with gaps
  task automatic test_random(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > count) burst = count;
      for (int i = 0; i < burst; i++) send_face(rand_face(), i != burst - 1);
      count -= burst;
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    drain();
  endtask

  task automatic set_config(input bit visc, input q_t fu, input q_t fv, input q_t fp,
                            input q_t fh, input q_t ire, input q_t hc);
    write_reg(REG_VISCOUS_ENABLE, q_t'(visc));
    write_reg(REG_FREE_U, fu);
    write_reg(REG_FREE_V, fv);
    write_reg(REG_FREE_PRESSURE, fp);
    write_reg(REG_FREE_ENTHALPY, fh);
    write_reg(REG_INV_REYNOLDS, ire);
    write_reg(REG_HEAT_COEF, hc);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Reset settings, then viscous on with moderate values
    test_directed();
    set_config(1, q_t'(32'sh0000f000), q_t'(32'sh00002000), q_t'(32'sh00012000),
               q_t'(32'sh00030000), q_t'(32'sh00000100), q_t'(32'sh00000080));
    stall_mode = 1;
    test_directed();
    test_random(150);
    // Extreme register values under heavy output stall
    set_config(1, q_t'(W_MAX), q_t'(W_MIN), q_t'(W_MAX), q_t'(W_MIN), q_t'(W_MAX),
               q_t'(W_MIN));
    stall_mode = 2;
    test_random(100);
    set_config(0, q_t'(W_MIN), q_t'(W_MAX), q_t'(W_MIN), q_t'(W_MAX), q_t'(W_MIN),
               q_t'(W_MAX));
    stall_mode = 0;
    test_random(100);
    set_config(1, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
               rand_word());
    stall_mode = 1;
    test_random(150);
    $display("faces sent %0d, results checked %0d over five register settings",
             faces_sent, fluxes_seen);
    $display("kinds 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", kind_hits[0], kind_hits[1],
             kind_hits[2], kind_hits[3], kind_hits[4], kind_hits[5], kind_hits[6],
             kind_hits[7]);
    if (errors == 0 && flux_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
